>>> src/cwa_pkg.sv
// Shared constants and types for the centered window average block.
`timescale 1ns / 1ps

package cwa_pkg;

    // Default build parameters.
    localparam int RADIUS_MAX_DEFAULT  = 63;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    // Width of the radius configuration input.
    localparam int CFG_BITS = 6;

    // Per-sample sequencing states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_PUSH,
        ST_FLUSH
    } cwa_state_t;

endpackage

>>> src/cwa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module cwa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 127
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/cwa_div.sv
// Restoring divider that produces one quotient bit per clock cycle.
`timescale 1ns / 1ps

module cwa_div #(
    parameter int DIVIDEND_BITS = 23,
    parameter int DIVISOR_BITS  = 7,
    parameter int QUOT_BITS     = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     done,
    output logic [QUOT_BITS-1:0]     quotient
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS);

    logic                     busy_reg;
    logic                     done_reg;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic [DIVISOR_BITS-1:0]  divisor_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  rem_next;
    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;
    logic                     q_bit;

    // The quotient register also holds the dividend bits not yet consumed.
    always_comb begin
        trial = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        diff  = trial - {1'b0, divisor_reg};
        q_bit = ~diff[DIVISOR_BITS];
        if (q_bit) begin
            rem_next = diff[DIVISOR_BITS-1:0];
        end else begin
            rem_next = trial[DIVISOR_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(DIVIDEND_BITS - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - CNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            divisor_reg <= divisor;
            rem_reg     <= '0;
            quo_reg     <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[QUOT_BITS-1:0];

endmodule

>>> src/centered_window_average.sv
// Top level of the centered window average: delay line RAM, running sum and sequencer.
// A sample yields an average through the bit-serial divider, an invalid result, or
// nothing; samples are processed one at a time, and a final sample also emits its
// flushed results before the next sample is taken.
// Reset (aresetn low, synchronous) clears radius, sum, counters, the sequencer state and the output valid flag.
`timescale 1ns / 1ps

module centered_window_average #(
    parameter int RADIUS_MAX  = cwa_pkg::RADIUS_MAX_DEFAULT,
    parameter int SAMPLE_BITS = cwa_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Radius configuration write channel.
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [cwa_pkg::CFG_BITS-1:0] cfg_radius,
    // Sample input channel.
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [SAMPLE_BITS-1:0]    s_sample,
    input  logic                      s_final_sample,
    // Result output channel.
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [SAMPLE_BITS-1:0]    m_average,
    output logic                      m_has_average,
    output logic                      m_run_end
);

    localparam int RADIUS_BITS = $clog2(RADIUS_MAX + 1);
    localparam int STORE_DEPTH = 2 * RADIUS_MAX + 1;
    localparam int SLOT_BITS   = $clog2(STORE_DEPTH);
    localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;

    cwa_pkg::cwa_state_t state_reg, state_next;

    // Sequence state. The window size 2k+1 fits in SLOT_BITS.
    logic [RADIUS_BITS-1:0] k_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SLOT_BITS-1:0]   seen_reg;
    logic [SLOT_BITS-1:0]   slot_reg;

    // Per-sample working registers.
    logic [SAMPLE_BITS-1:0] x_reg;
    logic                   fin_reg;
    logic [SLOT_BITS-1:0]   s_reg;
    logic [SAMPLE_BITS-1:0] res_avg_reg;
    logic                   res_has_reg;
    logic [RADIUS_BITS-1:0] flush_reg;

    // Output stage.
    logic                   m_valid_reg;
    logic [SAMPLE_BITS-1:0] m_average_reg;
    logic                   m_has_average_reg;
    logic                   m_run_end_reg;

    logic [SLOT_BITS-1:0]   k_ext;
    logic [SLOT_BITS-1:0]   two_k;
    logic [SLOT_BITS-1:0]   win_size;
    logic [SLOT_BITS-1:0]   slot_adv;
    logic [SLOT_BITS-1:0]   pend_wide;
    logic [SAMPLE_BITS-1:0] ram_rd_data;
    logic [SAMPLE_BITS-1:0] oldest;
    logic [SAMPLE_BITS-1:0] div_quotient;
    logic                   div_done;
    logic                   out_free;
    logic                   cfg_fire;
    logic                   in_fire;
    logic                   s_before;
    logic                   s_full;
    logic                   div_start;
    logic                   load_res;
    logic                   load_flush;
    logic [RADIUS_BITS-1:0] k_cfg;

    assign k_ext    = SLOT_BITS'(k_reg);
    assign two_k    = {k_reg, 1'b0};
    assign win_size = {k_reg, 1'b1};

    // The slot after the current one, wrapping at the window size. It is both the
    // next write slot and the slot of the oldest sample once the window is full.
    assign slot_adv = (slot_reg == two_k) ? '0 : slot_reg + SLOT_BITS'(1);

    // Classification of the sample being processed by its count of predecessors.
    assign s_before  = (s_reg < k_ext);
    assign s_full    = (s_reg >= two_k);
    assign pend_wide = s_reg + SLOT_BITS'(1) - k_ext;

    // With a window of one the oldest slot is the one just written, whose RAM read
    // returned stale contents, so the sample itself is forwarded.
    assign oldest = (k_reg == '0) ? x_reg : ram_rd_data;

    assign out_free  = ~m_valid_reg | m_ready;
    assign cfg_ready = (state_reg == cwa_pkg::ST_IDLE);
    assign s_ready   = (state_reg == cwa_pkg::ST_IDLE) & ~cfg_valid;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign in_fire   = s_valid & s_ready;

    assign k_cfg = (cfg_radius > cwa_pkg::CFG_BITS'(RADIUS_MAX)) ?
                   RADIUS_BITS'(RADIUS_MAX) : cfg_radius[RADIUS_BITS-1:0];

    cwa_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (in_fire),
        .wr_addr (slot_reg),
        .wr_data (s_sample),
        .rd_addr (slot_adv),
        .rd_data (ram_rd_data)
    );

    cwa_div #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (SLOT_BITS),
        .QUOT_BITS     (SAMPLE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (win_size),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cwa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer: transfer, then the RAM read returns the oldest sample, then either
    // a division, an invalid result, or nothing, followed by any flush results.
    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        load_res   = 1'b0;
        load_flush = 1'b0;
        case (state_reg)
            cwa_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = cwa_pkg::ST_CALC;
                end
            end
            cwa_pkg::ST_CALC: begin
                if (s_before) begin
                    state_next = cwa_pkg::ST_PUSH;
                end else if (s_full) begin
                    div_start  = 1'b1;
                    state_next = cwa_pkg::ST_DIV;
                end else if (fin_reg) begin
                    state_next = cwa_pkg::ST_FLUSH;
                end else begin
                    state_next = cwa_pkg::ST_IDLE;
                end
            end
            cwa_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = cwa_pkg::ST_PUSH;
                end
            end
            cwa_pkg::ST_PUSH: begin
                if (out_free) begin
                    load_res = 1'b1;
                    if (flush_reg != '0) begin
                        state_next = cwa_pkg::ST_FLUSH;
                    end else begin
                        state_next = cwa_pkg::ST_IDLE;
                    end
                end
            end
            cwa_pkg::ST_FLUSH: begin
                if (out_free) begin
                    load_flush = 1'b1;
                    if (flush_reg == RADIUS_BITS'(1)) begin
                        state_next = cwa_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = cwa_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequence state: the radius write restarts the sequence, a transfer adds the
    // sample, and in the next cycle the oldest sample leaves the sum once the window
    // is full. A final sample clears the sum, the count and the write slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg    <= '0;
            sum_reg  <= '0;
            seen_reg <= '0;
            slot_reg <= '0;
        end else if (cfg_fire) begin
            k_reg    <= k_cfg;
            sum_reg  <= '0;
            seen_reg <= '0;
            slot_reg <= '0;
        end else if (in_fire) begin
            sum_reg <= sum_reg + SUM_BITS'(s_sample);
            if (s_final_sample) begin
                seen_reg <= '0;
                slot_reg <= '0;
            end else begin
                seen_reg <= (seen_reg < two_k) ? seen_reg + SLOT_BITS'(1) : two_k;
                slot_reg <= slot_adv;
            end
        end else if (state_reg == cwa_pkg::ST_CALC) begin
            if (fin_reg) begin
                sum_reg <= '0;
            end else if (s_full) begin
                sum_reg <= sum_reg - SUM_BITS'(oldest);
            end
        end
    end

    // Working registers for the sample in flight.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            x_reg   <= s_sample;
            fin_reg <= s_final_sample;
            s_reg   <= seen_reg;
        end
        if (state_reg == cwa_pkg::ST_CALC) begin
            res_avg_reg <= '0;
            res_has_reg <= 1'b0;
            if (!fin_reg || s_before) begin
                flush_reg <= '0;
            end else if (s_full) begin
                flush_reg <= k_reg;
            end else begin
                flush_reg <= pend_wide[RADIUS_BITS-1:0];
            end
        end else if (state_reg == cwa_pkg::ST_DIV && div_done) begin
            res_avg_reg <= div_quotient;
            res_has_reg <= 1'b1;
        end else if (load_flush) begin
            flush_reg <= flush_reg - RADIUS_BITS'(1);
        end
    end

    // Output register; it parts the sequencer from a stalled consumer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_res || load_flush) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_res) begin
            m_average_reg     <= res_avg_reg;
            m_has_average_reg <= res_has_reg;
            m_run_end_reg     <= (flush_reg == '0);
        end else if (load_flush) begin
            m_average_reg     <= '0;
            m_has_average_reg <= 1'b0;
            m_run_end_reg     <= (flush_reg == RADIUS_BITS'(1));
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_average     = m_average_reg;
    assign m_has_average = m_has_average_reg;
    assign m_run_end     = m_run_end_reg;

endmodule

>>> src/cwa_checker.sv
// Port-level assertions for the centered window average, bound to the top level.
`timescale 1ns / 1ps

module cwa_checker #(
    parameter int SAMPLE_BITS = cwa_pkg::SAMPLE_BITS_DEFAULT
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [SAMPLE_BITS-1:0] m_average,
    input logic                   m_has_average,
    input logic                   m_run_end
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_average)
            && $stable(m_has_average) && $stable(m_run_end))
        else $error("result changed while stalled");

    // An invalid result carries a zero average.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_average |-> m_average == '0)
        else $error("invalid result with nonzero average");

    // Samples are processed one at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("sample accepted on consecutive cycles");

    // While a sample still owes results, no new sample is taken.
    a_run_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_run_end |-> !s_ready)
        else $error("sample accepted before run end delivered");

endmodule

bind centered_window_average cwa_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_cwa_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_average     (m_average),
    .m_has_average (m_has_average),
    .m_run_end     (m_run_end)
);

>>> test/tb_top.sv
// Self-checking testbench for the centered window average block.
`timescale 1ns / 1ps

module tb_top;

    localparam int SAMPLE_W     = 16;
    localparam int CFG_W        = cwa_pkg::CFG_BITS;
    localparam int LINE_DEPTH   = 127;
    // The idle wait of SETTLE_CYCLES lets a sample that yields only an average settle,
    // so that nothing is still in flight before the radius changes.
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 325;
    localparam int HOLD_AFTER    = 30;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                has_average;
        logic                run_end;
    } window_result_t;

    typedef enum logic {
        ROW_RADIUS,
        ROW_SAMPLE
    } row_kind_t;

    // One row of the directed script. A radius row carries the new half width in value.
    // A typed row carries its single result; all other rows rely on the predictor.
    typedef struct packed {
        row_kind_t           kind;
        logic [SAMPLE_W-1:0] value;
        logic                last;
        logic                typed;
        logic [SAMPLE_W-1:0] average;
        logic                has_average;
    } script_row_t;

    localparam int SCRIPT_ROWS = 29;

    script_row_t script [0:SCRIPT_ROWS-1] = '{
        // Radius zero: every sample is its own average.
        '{ROW_RADIUS, 16'd0,    1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 1'b1},
        '{ROW_SAMPLE, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b1},
        '{ROW_SAMPLE, 16'h8001, 1'b1, 1'b1, 16'h8001, 1'b1},
        // Half width two: leading positions, waiting positions, full windows of
        // the largest sample, and a last sample that flushes two positions.
        '{ROW_RADIUS, 16'd2,    1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h0064, 1'b0, 1'b1, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h00C8, 1'b0, 1'b1, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h012C, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h0190, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b1, 1'b0, 16'h0000, 1'b0},
        // Sequence that ends while still inside the leading positions.
        '{ROW_SAMPLE, 16'h0005, 1'b0, 1'b1, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h0006, 1'b1, 1'b1, 16'h0000, 1'b0},
        // Sequences that end while positions are still waiting for neighbors.
        '{ROW_SAMPLE, 16'h0007, 1'b0, 1'b1, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h0008, 1'b0, 1'b1, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h0009, 1'b1, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h000A, 1'b0, 1'b1, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h000B, 1'b0, 1'b1, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h000C, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h000D, 1'b1, 1'b0, 16'h0000, 1'b0},
        // Widest window: a lone last sample is simply invalid.
        '{ROW_RADIUS, 16'd63,   1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 1'b0},
        // Half width one: the first full window arrives on the last sample.
        '{ROW_RADIUS, 16'd1,    1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h0001, 1'b0, 1'b1, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h0002, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h0003, 1'b1, 1'b0, 16'h0000, 1'b0}
    };

    logic                aclk;
    logic                aresetn        = 1'b0;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_radius     = '0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_sample       = '0;
    logic                s_final_sample = 1'b0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [SAMPLE_W-1:0] m_average;
    logic                m_has_average;
    logic                m_run_end;

    // Predictor state: delay line, running sum, fill count and write slot.
    logic [SAMPLE_W-1:0] delay_line [0:LINE_DEPTH-1];
    longint unsigned     run_sum;
    int unsigned         fill_count;
    int unsigned         head_slot;
    int unsigned         half_width;

    window_result_t      step_results [$];
    window_result_t      pending_averages [$];

    int unsigned         mismatch_count;
    int unsigned         taken_count;
    int unsigned         send_gap_max;
    int unsigned         take_gap_max;

    centered_window_average u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_radius     (cfg_radius),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_final_sample (s_final_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_average      (m_average),
        .m_has_average  (m_has_average),
        .m_run_end      (m_run_end)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic void drop_sequence();
        run_sum    = 0;
        fill_count = 0;
        head_slot  = 0;
    endfunction

    function automatic void push_step(logic [SAMPLE_W-1:0] avg, logic valid);
        window_result_t r;
        r.average     = avg;
        r.has_average = valid;
        r.run_end     = 1'b0;
        step_results.push_back(r);
    endfunction

    // Advances the window by one sample and leaves the results it causes in step_results.
    function automatic void advance_window(logic [SAMPLE_W-1:0] x, logic last);
        int unsigned k;
        int unsigned span;
        int unsigned slot;
        int unsigned seen;
        int unsigned flush;
        window_result_t r;
        k    = half_width;
        span = 2 * k + 1;
        slot = head_slot % span;
        seen = fill_count;
        step_results.delete();
        delay_line[slot] = x;
        run_sum += x;
        if (seen < k) begin
            push_step('0, 1'b0);
        end else if (seen >= 2 * k) begin
            push_step(SAMPLE_W'(run_sum / span), 1'b1);
            // The oldest sample leaves the window once the centered position is out.
            run_sum -= delay_line[(slot + 1) % span];
        end
        if (last) begin
            if (seen < k)
                flush = 0;
            else if (seen >= 2 * k)
                flush = k;
            else
                flush = seen + 1 - k;
            repeat (flush) push_step('0, 1'b0);
            drop_sequence();
        end else begin
            fill_count = (seen < 2 * k) ? seen + 1 : 2 * k;
            head_slot  = (slot + 1 == span) ? 0 : slot + 1;
        end
        if (step_results.size() > 0) begin
            r = step_results.pop_back();
            r.run_end = 1'b1;
            step_results.push_back(r);
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: pick_sample = '0;
            1: pick_sample = '1;
            default: pick_sample = SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offers one sample after a random gap and records what it should produce.
    // On return the sample has just been taken and s_valid is still high, so the
    // caller either offers the next sample or lowers valid in the same time step.
    task automatic offer_sample(logic [SAMPLE_W-1:0] x, logic last, logic typed,
                                window_result_t typed_res);
        int unsigned gap;
        int unsigned i;
        gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample       <= x;
        s_final_sample <= last;
        do @(posedge aclk); while (!s_ready);
        advance_window(x, last);
        if (typed) begin
            pending_averages.push_back(typed_res);
        end else begin
            for (i = 0; i < step_results.size(); i++)
                pending_averages.push_back(step_results[i]);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge aclk);
    endtask

    // A radius write is only issued once the block has gone quiet.
    task automatic load_radius(logic [CFG_W-1:0] r);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid  <= 1'b1;
        cfg_radius <= r;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        half_width = r;
        drop_sequence();
    endtask

    // Sends one sequence of random samples. An open sequence gets no last flag and is
    // later dropped by the next radius write. A few stray last flags end it early.
    task automatic run_sequence(int unsigned len, bit closed);
        int unsigned i;
        logic last;
        window_result_t none;
        none = '0;
        for (i = 0; i < len; i++) begin
            if (i == len - 1)
                last = closed;
            else
                last = ($urandom_range(0, 39) == 0);
            offer_sample(pick_sample(), last, 1'b0, none);
        end
    endtask

    // Result side: random ready gaps, plus one long hold-off that backs the block up.
    initial begin
        int unsigned gap;
        window_result_t want;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken_count == HOLD_AFTER)
                gap = HOLD_CYCLES;
            else if (take_gap_max == 0)
                gap = 0;
            else
                gap = $urandom_range(0, take_gap_max);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken_count++;
            if (pending_averages.size() == 0) begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("unexpected result: avg %h has %b end %b",
                             m_average, m_has_average, m_run_end);
                mismatch_count++;
            end else begin
                want = pending_averages.pop_front();
                if (want.average !== m_average || want.has_average !== m_has_average ||
                    want.run_end !== m_run_end) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display({"mismatch: expected avg %h has %b end %b, ",
                                  "got avg %h has %b end %b"},
                                 want.average, want.has_average, want.run_end,
                                 m_average, m_has_average, m_run_end);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int unsigned row;
        int unsigned drawn;
        int unsigned phase;
        int unsigned budget;
        int unsigned used;
        int unsigned len;
        int unsigned r;
        int unsigned waited;
        bit paused;
        window_result_t typed_res;

        mismatch_count = 0;
        taken_count    = 0;
        send_gap_max   = 11;
        take_gap_max   = 11;
        half_width     = 0;
        drop_sequence();
        for (row = 0; row < LINE_DEPTH; row++)
            delay_line[row] = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed script.
        for (row = 0; row < SCRIPT_ROWS; row++) begin
            if (script[row].kind == ROW_RADIUS) begin
                load_radius(CFG_W'(script[row].value));
            end else begin
                typed_res.average     = script[row].average;
                typed_res.has_average = script[row].has_average;
                typed_res.run_end     = 1'b1;
                offer_sample(script[row].value, script[row].last, script[row].typed,
                             typed_res);
            end
        end

        // Random phases: the first uses the widest window with a full-length sequence so
        // that a last sample flushes the largest number of positions.
        drawn  = 0;
        phase  = 0;
        paused = 1'b0;
        while (drawn < RANDOM_ITEMS) begin
            if (phase == 0)
                r = 63;
            else if ($urandom_range(0, 3) == 0)
                r = $urandom_range(0, 63);
            else
                r = $urandom_range(0, 6);
            send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
            take_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
            load_radius(CFG_W'(r));
            if (phase == 0) begin
                len = $urandom_range(127, 140);
                run_sequence(len, 1'b1);
                drawn += len;
            end else begin
                budget = $urandom_range(15, 40);
                used   = 0;
                while (used < budget && drawn + used < RANDOM_ITEMS) begin
                    len = $urandom_range(1, 2 * r + 9);
                    if (len > RANDOM_ITEMS - drawn - used)
                        len = RANDOM_ITEMS - drawn - used;
                    run_sequence(len, $urandom_range(0, 5) != 0);
                    used += len;
                    // Once, the source stops in the middle of a phase until all
                    // outstanding results have been delivered.
                    if (phase == 2 && !paused) begin
                        drain_results();
                        paused = 1'b1;
                    end
                end
                drawn += used;
            end
            phase++;
        end

        s_valid <= 1'b0;
        waited = 0;
        while (pending_averages.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_averages.size() != 0) begin
            $display("%0d expected results never arrived", pending_averages.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
